@@ rtl/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg
// types, character and operator codes shared by the command tokenizer
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int unsigned MAX_RES = 4;

  // command bytes with a meaning of their own
  localparam logic [7:0] CH_TWO    = 8'h32;  // 2
  localparam logic [7:0] CH_GT     = 8'h3e;  // >
  localparam logic [7:0] CH_PIPE   = 8'h7c;  // |
  localparam logic [7:0] CH_LT     = 8'h3c;  // <
  localparam logic [7:0] CH_AMP    = 8'h26;  // &
  localparam logic [7:0] CH_SEMI   = 8'h3b;  // ;
  localparam logic [7:0] CH_BSLASH = 8'h5c;  // backslash
  localparam logic [7:0] CH_SQUOTE = 8'h27;  // single quote
  localparam logic [7:0] CH_DQUOTE = 8'h22;  // double quote
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // operator codes
  localparam logic [3:0] OP_PIPE     = 4'd0;
  localparam logic [3:0] OP_OR       = 4'd1;
  localparam logic [3:0] OP_GT       = 4'd2;
  localparam logic [3:0] OP_GT_GT    = 4'd3;
  localparam logic [3:0] OP_GT_AMP   = 4'd4;
  localparam logic [3:0] OP_LT       = 4'd5;
  localparam logic [3:0] OP_LT_LT    = 4'd6;
  localparam logic [3:0] OP_AMP      = 4'd7;
  localparam logic [3:0] OP_AND      = 4'd8;
  localparam logic [3:0] OP_SEMI     = 4'd9;
  localparam logic [3:0] OP_SEMI2    = 4'd10;
  localparam logic [3:0] OP_TWO_GT   = 4'd11;
  localparam logic [3:0] OP_TWO_GTGT = 4'd12;

  localparam logic [0:0] KIND_CHAR = 1'b0;
  localparam logic [0:0] KIND_END  = 1'b1;

  typedef enum logic [1:0] {
    RK_BYTE     = 2'd0,
    RK_WORD_END = 2'd1,
    RK_OP       = 2'd2,
    RK_CMD_END  = 2'd3
  } rkind_e;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_e;

  typedef enum logic [2:0] {
    HOLD_NONE   = 3'd0,
    HOLD_TWO    = 3'd1,
    HOLD_TWO_GT = 3'd2,
    HOLD_PIPE   = 3'd3,
    HOLD_GT     = 3'd4,
    HOLD_LT     = 3'd5,
    HOLD_AMP    = 3'd6,
    HOLD_SEMI   = 3'd7
  } hold_e;

  typedef struct packed {
    quote_e      quote;
    logic        esc;
    hold_e       held;
    logic [8:0]  tokens;
    logic        limit;
    logic        in_word;
  } sct_state_t;

  localparam sct_state_t STATE_RST = '{
    quote: Q_NONE, esc: 1'b0, held: HOLD_NONE, tokens: 9'd0, limit: 1'b0, in_word: 1'b0
  };

  typedef struct packed {
    rkind_e      rkind;
    logic [7:0]  data;
    logic [3:0]  op;
    logic [8:0]  toks;
  } res_t;

  typedef struct packed {
    logic [2:0]            count;
    res_t [MAX_RES-1:0]    res;
  } bundle_t;

  function automatic hold_e op_hold(logic [7:0] ch);
    hold_e h;
    unique case (ch)
      CH_PIPE: h = HOLD_PIPE;
      CH_GT:   h = HOLD_GT;
      CH_LT:   h = HOLD_LT;
      CH_AMP:  h = HOLD_AMP;
      CH_SEMI: h = HOLD_SEMI;
      default: h = HOLD_NONE;
    endcase
    return h;
  endfunction

  function automatic logic [7:0] op_char(hold_e h);
    logic [7:0] ch;
    unique case (h)
      HOLD_PIPE: ch = CH_PIPE;
      HOLD_GT:   ch = CH_GT;
      HOLD_LT:   ch = CH_LT;
      HOLD_AMP:  ch = CH_AMP;
      HOLD_SEMI: ch = CH_SEMI;
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] op_single(hold_e h);
    logic [3:0] op;
    unique case (h)
      HOLD_GT:   op = OP_GT;
      HOLD_LT:   op = OP_LT;
      HOLD_AMP:  op = OP_AMP;
      HOLD_SEMI: op = OP_SEMI;
      default:   op = OP_PIPE;
    endcase
    return op;
  endfunction

  function automatic logic [3:0] op_pair(hold_e h);
    logic [3:0] op;
    unique case (h)
      HOLD_GT:   op = OP_GT_GT;
      HOLD_LT:   op = OP_LT_LT;
      HOLD_AMP:  op = OP_AND;
      HOLD_SEMI: op = OP_SEMI2;
      default:   op = OP_OR;
    endcase
    return op;
  endfunction

endpackage

@@ rtl/sct_in_if.sv @@
// ----------------------------------------------------------------------------
// sct_in_if
// command input channel: one byte or end-of-command marker per word
// ----------------------------------------------------------------------------
interface sct_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_in;

  modport source (output valid, kind, char_in, input ready);
  modport sink   (input valid, kind, char_in, output ready);
endinterface

@@ rtl/sct_out_if.sv @@
// ----------------------------------------------------------------------------
// sct_out_if
// tokenizer result channel: word bytes, word ends, operators, command end
// ----------------------------------------------------------------------------
interface sct_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] word_byte;
  logic [3:0] operator_code;
  logic [8:0] tokens_so_far;
  logic       last;

  modport source (output valid, result_kind, word_byte, operator_code, tokens_so_far, last,
                  input ready);
  modport sink   (input valid, result_kind, word_byte, operator_code, tokens_so_far, last,
                  output ready);
endinterface

@@ rtl/sct_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sct_cfg_if
// configuration write channel for the token limit register
// ----------------------------------------------------------------------------
interface sct_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] tok_limit;

  modport source (output valid, tok_limit, input ready);
  modport sink   (input valid, tok_limit, output ready);
endinterface

@@ rtl/sct_step.sv @@
// ----------------------------------------------------------------------------
// sct_step
// next-state and result logic for one command word
// ----------------------------------------------------------------------------
module sct_step
  import sct_pkg::*;
#(
  parameter int unsigned WORD_BUFFER = 4096,
  parameter int unsigned WL          = $clog2(WORD_BUFFER)
) (
  input  sct_state_t    state_i,
  input  logic [WL-1:0] wlen_i,
  input  logic          kind_i,
  input  logic [7:0]    char_i,
  input  logic [8:0]    tok_limit_i,
  output sct_state_t    state_o,
  output logic [WL-1:0] wlen_o,
  output bundle_t       bundle_o
);

  localparam logic [WL-1:0] WORD_CAP = WL'(WORD_BUFFER - 1);

  typedef struct packed {
    sct_state_t    st;
    logic [WL-1:0] wl;
    bundle_t       b;
  } ctx_t;

  function automatic ctx_t f_emit(ctx_t c, rkind_e k, logic [7:0] data, logic [3:0] op,
                                  logic [8:0] toks);
    ctx_t r;
    r = c;
    if (r.b.count < 3'(MAX_RES)) begin
      r.b.res[r.b.count[1:0]] = '{rkind: k, data: data, op: op, toks: toks};
      r.b.count = r.b.count + 3'd1;
    end
    return r;
  endfunction

  function automatic ctx_t f_count(ctx_t c, logic [8:0] mx);
    ctx_t r;
    r = c;
    if (r.st.tokens != 9'h1ff) begin
      r.st.tokens = r.st.tokens + 9'd1;
    end
    if (r.st.tokens >= mx) begin
      r.st.limit = 1'b1;
    end
    return r;
  endfunction

  function automatic ctx_t f_emit_op(ctx_t c, logic [3:0] op, logic [8:0] mx);
    ctx_t r;
    r = f_emit(c, RK_OP, 8'h00, op, 9'd0);
    r = f_count(r, mx);
    return r;
  endfunction

  function automatic ctx_t f_end_word(ctx_t c, logic [8:0] mx);
    ctx_t r;
    r = c;
    if (r.wl != '0) begin
      r = f_emit(r, RK_WORD_END, 8'h00, 4'd0, 9'd0);
      r = f_count(r, mx);
    end
    r.wl         = '0;
    r.st.quote   = Q_NONE;
    r.st.esc     = 1'b0;
    r.st.in_word = 1'b0;
    return r;
  endfunction

  function automatic ctx_t f_put(ctx_t c, logic [7:0] ch, logic [8:0] mx);
    ctx_t r;
    r = f_emit(c, RK_BYTE, ch, 4'd0, 9'd0);
    r.wl = r.wl + WL'(1);
    // word hit the buffer cap: close it right here
    if (r.wl >= WORD_CAP) begin
      r = f_end_word(r, mx);
    end
    return r;
  endfunction

  function automatic ctx_t f_at_top(ctx_t c, logic [7:0] ch, logic [8:0] mx);
    ctx_t r;
    r = c;
    if (r.st.limit || (r.st.tokens >= mx)) begin
      r.st.limit = 1'b1;
    end else if ((ch == CH_SPACE) || (ch == CH_TAB)) begin
      r.st.limit = r.st.limit;
    end else if (ch == CH_TWO) begin
      r.st.held = HOLD_TWO;
    end else if (op_hold(ch) != HOLD_NONE) begin
      r.st.held = op_hold(ch);
    end else begin
      r.st.in_word = 1'b1;
      if (ch == CH_SQUOTE) begin
        r.st.quote = Q_SINGLE;
      end else if (ch == CH_DQUOTE) begin
        r.st.quote = Q_DOUBLE;
      end else if (ch == CH_BSLASH) begin
        r.st.esc = 1'b1;
      end else begin
        r = f_put(r, ch, mx);
      end
    end
    return r;
  endfunction

  function automatic ctx_t f_in_word(ctx_t c, logic [7:0] ch, logic [8:0] mx);
    ctx_t r;
    r = c;
    if (r.st.esc) begin
      r.st.esc = 1'b0;
      r = f_put(r, ch, mx);
    end else if (r.st.quote != Q_NONE) begin
      if (((r.st.quote == Q_SINGLE) && (ch == CH_SQUOTE)) ||
          ((r.st.quote == Q_DOUBLE) && (ch == CH_DQUOTE))) begin
        r.st.quote = Q_NONE;
      end else if ((r.st.quote == Q_DOUBLE) && (ch == CH_BSLASH)) begin
        r.st.esc = 1'b1;
      end else begin
        r = f_put(r, ch, mx);
      end
    end else if (ch == CH_SQUOTE) begin
      r.st.quote = Q_SINGLE;
    end else if (ch == CH_DQUOTE) begin
      r.st.quote = Q_DOUBLE;
    end else if (ch == CH_BSLASH) begin
      r.st.esc = 1'b1;
    end else if ((ch == CH_SPACE) || (ch == CH_TAB) || (op_hold(ch) != HOLD_NONE)) begin
      r = f_end_word(r, mx);
      r = f_at_top(r, ch, mx);
    end else begin
      r = f_put(r, ch, mx);
    end
    return r;
  endfunction

  function automatic ctx_t f_take(ctx_t c, logic [7:0] ch, logic [8:0] mx);
    ctx_t  r;
    hold_e h;
    r = c;
    h = r.st.held;
    unique case (h)
      HOLD_NONE: begin
        if (r.st.in_word) begin
          r = f_in_word(r, ch, mx);
        end else begin
          r = f_at_top(r, ch, mx);
        end
      end
      HOLD_TWO: begin
        if (ch == CH_GT) begin
          r.st.held = HOLD_TWO_GT;
        end else begin
          // the held 2 turns out to start a word
          r.st.held    = HOLD_NONE;
          r.st.in_word = 1'b1;
          r = f_put(r, CH_TWO, mx);
          if (r.st.in_word) begin
            r = f_in_word(r, ch, mx);
          end else begin
            r = f_at_top(r, ch, mx);
          end
        end
      end
      HOLD_TWO_GT: begin
        r.st.held = HOLD_NONE;
        if (ch == CH_GT) begin
          r = f_emit_op(r, OP_TWO_GTGT, mx);
        end else begin
          r = f_emit_op(r, OP_TWO_GT, mx);
          r = f_at_top(r, ch, mx);
        end
      end
      default: begin
        r.st.held = HOLD_NONE;
        if (ch == op_char(h)) begin
          r = f_emit_op(r, op_pair(h), mx);
        end else if ((h == HOLD_GT) && (ch == CH_AMP)) begin
          r = f_emit_op(r, OP_GT_AMP, mx);
        end else begin
          r = f_emit_op(r, op_single(h), mx);
          r = f_at_top(r, ch, mx);
        end
      end
    endcase
    return r;
  endfunction

  function automatic ctx_t f_finish(ctx_t c, logic [8:0] mx);
    ctx_t  r;
    hold_e h;
    r = c;
    h = r.st.held;
    r.st.held = HOLD_NONE;
    unique case (h)
      HOLD_NONE: r.st.held = HOLD_NONE;
      HOLD_TWO: begin
        r.st.in_word = 1'b1;
        r = f_put(r, CH_TWO, mx);
      end
      HOLD_TWO_GT: r = f_emit_op(r, OP_TWO_GT, mx);
      default:     r = f_emit_op(r, op_single(h), mx);
    endcase
    // trailing backslash stays literal
    if (r.st.in_word && r.st.esc) begin
      r.st.esc = 1'b0;
      r = f_put(r, CH_BSLASH, mx);
    end
    if (r.st.in_word) begin
      r = f_end_word(r, mx);
    end
    r = f_emit(r, RK_CMD_END, 8'h00, 4'd0, r.st.tokens);
    r.st = STATE_RST;
    r.wl = '0;
    return r;
  endfunction

  ctx_t ctx_in;
  ctx_t ctx_out;

  always_comb begin
    ctx_in.st      = state_i;
    ctx_in.wl      = wlen_i;
    ctx_in.b.count = 3'd0;
    ctx_in.b.res   = '0;
    if (kind_i == KIND_END) begin
      ctx_out = f_finish(ctx_in, tok_limit_i);
    end else begin
      ctx_out = f_take(ctx_in, char_i, tok_limit_i);
    end
  end

  assign state_o  = ctx_out.st;
  assign wlen_o   = ctx_out.wl;
  assign bundle_o = ctx_out.b;

endmodule

@@ rtl/sct_out_buf.sv @@
// ----------------------------------------------------------------------------
// sct_out_buf
// result register holding up to four results, sent out one word per cycle while the output is ready
// ----------------------------------------------------------------------------
module sct_out_buf
  import sct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  bundle_t          bundle_i,
  output logic             free_o,
  sct_out_if.source        out_chan
);

  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  bundle_t    bundle_q;
  res_t       cur;
  logic       is_last;
  logic       out_fire;
  logic       drain_last;

  assign cur        = bundle_q.res[idx_q];
  assign is_last    = ({1'b0, idx_q} == (bundle_q.count - 3'd1));
  assign out_fire   = valid_q && out_chan.ready;
  assign drain_last = out_fire && is_last;
  assign free_o     = !valid_q || drain_last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (advance_i) begin
      // an item with no results leaves the buffer empty
      valid_d = (bundle_i.count != 3'd0);
      idx_d   = 2'd0;
    end else if (drain_last) begin
      valid_d = 1'b0;
    end else if (out_fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      bundle_q <= bundle_i;
    end
  end

  assign out_chan.valid         = valid_q;
  assign out_chan.result_kind   = cur.rkind;
  assign out_chan.word_byte     = cur.data;
  assign out_chan.operator_code = cur.op;
  assign out_chan.tokens_so_far = cur.toks;
  assign out_chan.last          = is_last;

  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((bundle_q.count != 3'd0) && ({1'b0, idx_q} < bundle_q.count)))
    else $error("result buffer holds an empty or overrun bundle");

  a_mid_bundle_stays : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !is_last) |=> (valid_q && (idx_q == $past(idx_q) + 2'd1)))
    else $error("bundle dropped before its last result");

endmodule

@@ rtl/shell_command_tokenizer.sv @@
// ----------------------------------------------------------------------------
// shell_command_tokenizer
// shell-style splitter of a command byte stream into words and operators
// ----------------------------------------------------------------------------
// A byte is taken into an input register, run through the tokenizer step
// logic, and its results (zero to four) are registered in a result register
// once it is free. One byte is accepted per cycle while each byte yields at
// most one result and the output is ready; a byte with more results holds
// up the input until the result register, draining one word per cycle while
// the output is ready, has sent them all. The token limit is written on the
// cfg channel, which is always ready; it resets to 256.
module shell_command_tokenizer
  import sct_pkg::*;
#(
  parameter int unsigned WORD_BUFFER = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sct_in_if.sink     in_chan,
  sct_out_if.source  out_chan,
  sct_cfg_if.sink    cfg_chan
);

  localparam int unsigned WL = $clog2(WORD_BUFFER);

  logic          in_valid_q;
  logic          in_kind_q;
  logic [7:0]    in_char_q;
  logic [8:0]    tok_limit_q;
  sct_state_t    state_q, state_d;
  logic [WL-1:0] wlen_q, wlen_d;
  bundle_t       bundle;
  logic          buf_free;
  logic          advance;

  assign advance       = in_valid_q && buf_free;
  assign in_chan.ready = !in_valid_q || advance;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      tok_limit_q <= 9'd256;
      state_q     <= STATE_RST;
      wlen_q      <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (cfg_chan.valid) begin
        tok_limit_q <= cfg_chan.tok_limit;
      end
      if (advance) begin
        state_q <= state_d;
        wlen_q  <= wlen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.valid && in_chan.ready) begin
      in_kind_q <= in_chan.kind;
      in_char_q <= in_chan.char_in;
    end
  end

  sct_step #(
    .WORD_BUFFER (WORD_BUFFER),
    .WL          (WL)
  ) u_step (
    .state_i     (state_q),
    .wlen_i      (wlen_q),
    .kind_i      (in_kind_q),
    .char_i      (in_char_q),
    .tok_limit_i (tok_limit_q),
    .state_o     (state_d),
    .wlen_o      (wlen_d),
    .bundle_o    (bundle)
  );

  sct_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .bundle_i  (bundle),
    .free_o    (buf_free),
    .out_chan  (out_chan)
  );

  // an operator or a 2 is only held between tokens
  a_held_outside_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.held != HOLD_NONE) |-> (!state_q.in_word && (wlen_q == '0) &&
                                     (state_q.quote == Q_NONE)))
    else $error("lookahead held inside a word");

  a_escape_in_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.esc |-> state_q.in_word)
    else $error("escape pending outside a word");

  a_item_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !buf_free) |=> (in_valid_q && $stable(state_q)))
    else $error("stalled item lost or state changed");

endmodule
